>>> sv/qat_pkg.sv
`default_nettype none
package qat_pkg;

    localparam int MAX_ARGS     = 32;
    localparam int BUFFER_BYTES = 4096;

    localparam int SLOT_W = 6;
    localparam int BUF_W  = 13;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;

    localparam logic [BUF_W-1:0]  LEN_SAT      = 13'd8191;
    localparam logic [SLOT_W-1:0] SLOTS_MAX    = 6'd32;
    localparam logic [BUF_W-1:0]  BYTES_MAX    = 13'd4096;
    localparam logic [7:0]        CH_BACKSLASH = 8'd92;
    localparam logic [7:0]        CH_DQUOTE    = 8'd34;
    localparam logic [7:0]        CH_SQUOTE    = 8'd39;

    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QCNT_W = 4;

    typedef enum logic [0:0] {
        REG_ARG_SLOTS    = 1'b0,
        REG_BUFFER_BYTES = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_END    = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_TOO_LONG    = 3'd2,
        ST_CONTROL     = 3'd3,
        ST_ARGS        = 3'd4,
        ST_QUOTE       = 3'd5,
        ST_OVERFLOW    = 3'd6,
        ST_EMPTY_FIRST = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_DOUBLE = 2'd1,
        Q_SINGLE = 2'd2
    } quote_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_char;
        logic [IDX_W-1:0] arg_index;
        status_t          status;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [SLOT_W-1:0] arg_slots;
        logic [BUF_W-1:0]  buffer_bytes;
    } cfg_t;

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_ctl(input logic [7:0] c);
        return (c < 8'd32) || (c == 8'd127);
    endfunction

endpackage
`default_nettype wire

>>> sv/qat_cfg.sv
`default_nettype none
module qat_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output qat_pkg::cfg_t      cfg
);
    import qat_pkg::*;

    logic [SLOT_W-1:0] arg_slots_reg;
    logic [BUF_W-1:0]  buffer_bytes_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_slots_reg    <= SLOTS_MAX;
            buffer_bytes_reg <= BYTES_MAX;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ARG_SLOTS:
                begin
                    arg_slots_reg <= (pwdata[5:0] > SLOTS_MAX) ? SLOTS_MAX : pwdata[5:0];
                end
                REG_BUFFER_BYTES:
                begin
                    buffer_bytes_reg <= (pwdata[12:0] > BYTES_MAX) ? BYTES_MAX
                                                                   : pwdata[12:0];
                end
                default:
                begin
                    arg_slots_reg <= arg_slots_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ARG_SLOTS:    prdata = {26'd0, arg_slots_reg};
            REG_BUFFER_BYTES: prdata = {19'd0, buffer_bytes_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg.arg_slots    = arg_slots_reg;
    assign cfg.buffer_bytes = buffer_bytes_reg;

endmodule
`default_nettype wire

>>> sv/qat_core.sv
`default_nettype none
module qat_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire qat_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    in_ch,
    input  wire logic          in_end,
    input  wire logic          space,
    output logic [1:0]         push_n,
    output qat_pkg::res_t      push_res [3]
);
    import qat_pkg::*;

    logic              valid_reg;
    logic [7:0]        ch_reg;
    logic              end_reg;
    logic              fire;

    logic              tok_reg, tok_next;
    quote_t            qm_reg, qm_next;
    logic              esc_reg, esc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BUF_W-1:0]  bw_reg, bw_next;
    logic [BUF_W-1:0]  len_reg, len_next;
    logic              ctl_reg, ctl_next;
    status_t           perr_reg, perr_next;
    logic              fane_reg, fane_next;

    logic              copy_req;
    logic              close_req;
    logic [7:0]        copy_ch;
    logic              room;
    logic              halted;
    quote_t            qc;
    status_t           st;
    logic [1:0]        n;
    res_t              res [3];

    assign fire     = valid_reg && space;
    assign in_ready = !valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ch_reg  <= in_ch;
            end_reg <= in_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= 1'b0;
            qm_reg   <= Q_NONE;
            esc_reg  <= 1'b0;
            cnt_reg  <= '0;
            bw_reg   <= '0;
            len_reg  <= '0;
            ctl_reg  <= 1'b0;
            perr_reg <= ST_OK;
            fane_reg <= 1'b0;
        end
        else
        begin
            tok_reg  <= tok_next;
            qm_reg   <= qm_next;
            esc_reg  <= esc_next;
            cnt_reg  <= cnt_next;
            bw_reg   <= bw_next;
            len_reg  <= len_next;
            ctl_reg  <= ctl_next;
            perr_reg <= perr_next;
            fane_reg <= fane_next;
        end
    end

    always_comb
    begin
        tok_next  = tok_reg;
        qm_next   = qm_reg;
        esc_next  = esc_reg;
        cnt_next  = cnt_reg;
        bw_next   = bw_reg;
        len_next  = len_reg;
        ctl_next  = ctl_reg;
        perr_next = perr_reg;
        fane_next = fane_reg;
        copy_req  = 1'b0;
        close_req = 1'b0;
        copy_ch   = ch_reg;
        room      = 1'b0;
        halted    = 1'b0;
        qc        = (ch_reg == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
        st        = ST_OK;
        n         = 2'd0;
        for (int k = 0; k < 3; k++)
        begin
            res[k] = '0;
        end

        if (fire && !end_reg)
        begin
            len_next = (len_reg < LEN_SAT) ? len_reg + 13'd1 : len_reg;
            ctl_next = ctl_reg | is_ctl(ch_reg);
            halted   = (len_next >= cfg.buffer_bytes) || ctl_next || (perr_reg != ST_OK);
            if (!halted)
            begin
                if (!tok_reg)
                begin
                    if (is_sep(ch_reg))
                    begin
                        halted = 1'b1;
                    end
                    else if (({1'b0, cnt_reg} + 7'd1) >= {1'b0, cfg.arg_slots})
                    begin
                        perr_next = ST_ARGS;
                        halted    = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                        tok_next = 1'b1;
                    end
                end
                if (!halted)
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        copy_req = 1'b1;
                    end
                    else if (qm_reg == Q_NONE && is_sep(ch_reg))
                    begin
                        close_req = 1'b1;
                    end
                    else if ((ch_reg == CH_DQUOTE || ch_reg == CH_SQUOTE) && qm_reg == Q_NONE)
                    begin
                        qm_next = qc;
                    end
                    else if ((ch_reg == CH_DQUOTE || ch_reg == CH_SQUOTE) && qm_reg == qc)
                    begin
                        qm_next = Q_NONE;
                    end
                    else if (ch_reg == CH_BACKSLASH && qm_reg != qc)
                    begin
                        esc_next = 1'b1;
                    end
                    else if (ch_reg == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        copy_req = 1'b1;
                    end
                end
            end
        end
        else if (fire)
        begin
            halted = (len_reg >= cfg.buffer_bytes) || ctl_reg || (perr_reg != ST_OK);
            if (!halted && esc_reg)
            begin
                esc_next = 1'b0;
                copy_req = 1'b1;
                copy_ch  = CH_BACKSLASH;
            end
        end

        if (copy_req)
        begin
            room = ({1'b0, bw_next} + 14'd1) < {1'b0, cfg.buffer_bytes};
            if (!room)
            begin
                perr_next = ST_OVERFLOW;
            end
            else
            begin
                bw_next = bw_next + 13'd1;
                if (cnt_next == 6'd1)
                begin
                    fane_next = 1'b1;
                end
                res[n].kind      = KIND_BYTE;
                res[n].out_char  = copy_ch;
                res[n].arg_index = IDX_W'(cnt_next - 6'd1);
                n = n + 2'd1;
            end
        end

        if (fire && end_reg && !halted && perr_next == ST_OK && tok_next)
        begin
            if (qm_next != Q_NONE)
            begin
                perr_next = ST_QUOTE;
            end
            else
            begin
                close_req = 1'b1;
            end
        end

        if (close_req)
        begin
            room = ({1'b0, bw_next} + 14'd1) < {1'b0, cfg.buffer_bytes};
            if (!room)
            begin
                perr_next = ST_OVERFLOW;
            end
            else
            begin
                bw_next  = bw_next + 13'd1;
                tok_next = 1'b0;
                res[n].kind      = KIND_END;
                res[n].arg_index = IDX_W'(cnt_next - 6'd1);
                n = n + 2'd1;
            end
        end

        if (fire && end_reg)
        begin
            if (len_reg == '0)
            begin
                st = ST_EMPTY;
            end
            else if (len_reg >= cfg.buffer_bytes)
            begin
                st = ST_TOO_LONG;
            end
            else if (ctl_reg)
            begin
                st = ST_CONTROL;
            end
            else if (perr_next != ST_OK)
            begin
                st = perr_next;
            end
            else if (cnt_next == '0 || !fane_next)
            begin
                st = ST_EMPTY_FIRST;
            end
            else
            begin
                st = ST_OK;
            end
            res[n].kind   = KIND_STATUS;
            res[n].status = st;
            res[n].last   = 1'b1;
            n = n + 2'd1;

            tok_next  = 1'b0;
            qm_next   = Q_NONE;
            esc_next  = 1'b0;
            cnt_next  = '0;
            bw_next   = '0;
            len_next  = '0;
            ctl_next  = 1'b0;
            perr_next = ST_OK;
            fane_next = 1'b0;
        end
    end

    assign push_n = n;
    assign push_res[0] = res[0];
    assign push_res[1] = res[1];
    assign push_res[2] = res[2];

endmodule
`default_nettype wire

>>> sv/qat_outq.sv
`default_nettype none
module qat_outq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [1:0]    push_n,
    input  wire qat_pkg::res_t push_res [3],
    output logic               space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output qat_pkg::res_t      out_res
);
    import qat_pkg::*;

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_res   = mem[rd_ptr_reg];
    assign space     = (count_reg <= QCNT_W'(QDEPTH - 3));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (k < int'(push_n))
            begin
                mem[wr_ptr_reg + QPTR_W'(k)] <= push_res[k];
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/quoted_argument_tokenizer_unit.sv
`default_nettype none
// Shell-style argument tokenizer.
// Input stream: one command-line byte per transfer on s_tdata; a transfer with
// s_tlast high is the line terminator and its data is ignored.
// Output stream: m_tuser gives the kind (byte, argument end, final status);
// m_tdata carries the byte, argument index and status; m_tlast marks the final
// status of a line. A nonzero status means the line's earlier output is void.
// Configuration: APB registers arg_slots (0x0) and buffer_bytes (0x4); the user
// must write them only while no line is in flight, as the block does not enforce it.
// The first result of a transfer passes the input register and then the output
// queue before it reaches m_tdata. Ordinary bytes sustain one transfer per cycle
// while the queue has room; a terminator yields up to three results, which drain
// one per cycle while m_tready is high, through an eight-entry output queue.
// s_tready drops while the input register holds a transfer and the queue has
// fewer than three free entries, so a stalled receiver backs up the input after
// a few transfers.
// Reset clears the line state and the queue and loads both registers with
// their maximum values.
module quoted_argument_tokenizer_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] ch
    input  wire logic          s_tlast,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic      [15:0]   m_tdata,   // [7:0] out_char, [12:8] arg_index, [15:13] status
    output logic      [1:0]    m_tuser,   // [1:0] kind
    output logic               m_tlast,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready
);
    import qat_pkg::*;

    cfg_t       cfg;
    logic       space;
    logic [1:0] push_n;
    res_t       push_res [3];
    res_t       out_res;

    qat_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qat_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_ch    (s_tdata),
        .in_end   (s_tlast),
        .space    (space),
        .push_n   (push_n),
        .push_res (push_res)
    );

    qat_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_res  (push_res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.status, out_res.arg_index, out_res.out_char};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
`default_nettype wire

>>> verif/quoted_argument_tokenizer_unit_tb.sv
`timescale 1ns / 100ps

module quoted_argument_tokenizer_unit_tb;

    import qat_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    class arg_line_scoreboard;
        logic [SLOT_W-1:0] slots_cfg;
        logic [BUF_W-1:0]  bytes_cfg;
        logic              in_arg;
        quote_t            quote_open;
        logic              escape_armed;
        logic [CNT_W-1:0]  args_opened;
        logic [BUF_W-1:0]  bytes_stored;
        logic [BUF_W-1:0]  line_len;
        logic              ctl_seen;
        status_t           first_error;
        logic              first_arg_filled;
        res_t              expected_q[$];
        int                mismatches;

        function new();
            slots_cfg = SLOTS_MAX;
            bytes_cfg = BYTES_MAX;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            in_arg = 1'b0;
            quote_open = Q_NONE;
            escape_armed = 1'b0;
            args_opened = '0;
            bytes_stored = '0;
            line_len = '0;
            ctl_seen = 1'b0;
            first_error = ST_OK;
            first_arg_filled = 1'b0;
        endfunction

        function void set_config(reg_idx_t idx, logic [31:0] value);
            if (idx == REG_ARG_SLOTS)
                slots_cfg = (value[SLOT_W-1:0] > SLOTS_MAX) ? SLOTS_MAX : value[SLOT_W-1:0];
            else
                bytes_cfg = (value[BUF_W-1:0] > BYTES_MAX) ? BYTES_MAX : value[BUF_W-1:0];
        endfunction

        function bit is_separator(logic [7:0] c);
            return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit has_room();
            return ({1'b0, bytes_stored} + 14'd1) < {1'b0, bytes_cfg};
        endfunction

        function bit stopped();
            return (line_len >= bytes_cfg) || ctl_seen || (first_error != ST_OK);
        endfunction

        function void push(kind_t k, logic [7:0] c, status_t st);
            res_t r;
            logic [CNT_W-1:0] idx;
            idx = args_opened - 1'b1;
            r.kind = k;
            r.out_char = c;
            r.arg_index = (k == KIND_STATUS) ? '0 : idx[IDX_W-1:0];
            r.status = st;
            r.last = (k == KIND_STATUS);
            expected_q.push_back(r);
        endfunction

        function void store_byte(logic [7:0] c);
            if (!has_room())
            begin
                first_error = ST_OVERFLOW;
                return;
            end
            bytes_stored++;
            if (args_opened == 1)
                first_arg_filled = 1'b1;
            push(KIND_BYTE, c, ST_OK);
        endfunction

        function void close_arg();
            if (!has_room())
            begin
                first_error = ST_OVERFLOW;
                return;
            end
            bytes_stored++;
            in_arg = 1'b0;
            push(KIND_END, 8'd0, ST_OK);
        endfunction

        function void parse(logic [7:0] c);
            quote_t q;
            if (!in_arg)
            begin
                if (is_separator(c))
                    return;
                if (({1'b0, args_opened} + 7'd1) >= {1'b0, slots_cfg})
                begin
                    first_error = ST_ARGS;
                    return;
                end
                args_opened++;
                in_arg = 1'b1;
            end
            if (escape_armed)
            begin
                escape_armed = 1'b0;
                store_byte(c);
                return;
            end
            if (quote_open == Q_NONE && is_separator(c))
            begin
                close_arg();
                return;
            end
            if (c == CH_DQUOTE || c == CH_SQUOTE)
            begin
                q = (c == CH_DQUOTE) ? Q_DOUBLE : Q_SINGLE;
                if (quote_open == Q_NONE)
                begin
                    quote_open = q;
                    return;
                end
                if (quote_open == q)
                begin
                    quote_open = Q_NONE;
                    return;
                end
            end
            if (c == CH_BACKSLASH)
            begin
                escape_armed = 1'b1;
                return;
            end
            store_byte(c);
        endfunction

        function void note_input(logic [7:0] ch, logic is_end);
            status_t st;
            if (!is_end)
            begin
                if (line_len < LEN_SAT)
                    line_len++;
                if (ch < 8'd32 || ch == 8'd127)
                    ctl_seen = 1'b1;
                if (!stopped())
                    parse(ch);
                return;
            end
            if (!stopped())
            begin
                if (escape_armed)
                begin
                    escape_armed = 1'b0;
                    store_byte(CH_BACKSLASH);
                end
                if (first_error == ST_OK && in_arg)
                begin
                    if (quote_open != Q_NONE)
                        first_error = ST_QUOTE;
                    else
                        close_arg();
                end
            end
            if (line_len == 0)
                st = ST_EMPTY;
            else if (line_len >= bytes_cfg)
                st = ST_TOO_LONG;
            else if (ctl_seen)
                st = ST_CONTROL;
            else if (first_error != ST_OK)
                st = first_error;
            else if (args_opened == 0 || !first_arg_filled)
                st = ST_EMPTY_FIRST;
            else
                st = ST_OK;
            push(KIND_STATUS, 8'd0, st);
            clear_line();
        endfunction

        function void report(string what, res_t want, res_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t %s: exp kind=%0d char=%h idx=%0d st=%0d last=%0b,",
                          " got kind=%0d char=%h idx=%0d st=%0d last=%0b"},
                    $realtime, what, want.kind, want.out_char, want.arg_index, want.status,
                    want.last, got.kind, got.out_char, got.arg_index, got.status, got.last);
        endfunction

        function void check_result(logic [1:0] user, logic [15:0] data, logic tl);
            res_t want;
            res_t got;
            got.kind = kind_t'(user);
            got.out_char = data[7:0];
            got.arg_index = data[12:8];
            got.status = status_t'(data[15:13]);
            got.last = tl;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", got, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.out_char !== want.out_char
                || got.arg_index !== want.arg_index || got.status !== want.status
                || got.last !== want.last)
                report("result mismatch", want, got);
        endfunction

        function void flush_leftovers();
            res_t want;
            while (expected_q.size() != 0)
            begin
                want = expected_q.pop_front();
                report("missing result", want, want);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;     // [7:0] ch
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [7:0] out_char, [12:8] arg_index, [15:13] status
    logic [1:0]  m_tuser;            // [1:0] kind
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    arg_line_scoreboard sb = new();

    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    int items_sent = 0;
    int stuck_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;

    quoted_argument_tokenizer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // hold off for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_config(idx, value);
        @(posedge clk);
    endtask

    task automatic send_item(input logic [7:0] ch, input logic is_end);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= is_end;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_line(ref logic [7:0] line_q[$]);
        foreach (line_q[i])
            send_item(line_q[i], 1'b0);
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] line_q[$];
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
        send_line(line_q);
    endtask

    // drop valid, drain every pending result, then let the pipeline settle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_sep();
        if ($urandom_range(9) < 6)
            return 8'd32;
        return 8'($urandom_range(13, 9));
    endfunction

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 8'($urandom_range(122, 97));
        if (r < 90)
        begin
            c = 8'($urandom_range(126, 33));
            while (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BACKSLASH)
                c = 8'($urandom_range(126, 33));
            return c;
        end
        return 8'($urandom_range(255, 128));
    endfunction

    function automatic void build_line(ref logic [7:0] line_q[$], input int max_args);
        int nargs;
        logic [7:0] qc;
        line_q.delete();
        nargs = $urandom_range(max_args);
        repeat ($urandom_range(1)) line_q.push_back(pick_sep());
        for (int a = 0; a < nargs; a++)
        begin
            if (a > 0)
                repeat ($urandom_range(2, 1)) line_q.push_back(pick_sep());
            repeat ($urandom_range(2, 1))
            begin
                qc = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                case ($urandom_range(4))
                    0, 1: repeat ($urandom_range(3, 1)) line_q.push_back(pick_plain());
                    2:
                    begin
                        line_q.push_back(qc);
                        repeat ($urandom_range(3))
                        begin
                            case ($urandom_range(3))
                                0: line_q.push_back(pick_plain());
                                1: line_q.push_back(pick_sep());
                                2: line_q.push_back(qc == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
                                default:
                                begin
                                    line_q.push_back(CH_BACKSLASH);
                                    line_q.push_back(qc);
                                end
                            endcase
                        end
                        line_q.push_back(qc);
                    end
                    3:
                    begin
                        line_q.push_back(CH_BACKSLASH);
                        line_q.push_back(8'($urandom_range(126, 32)));
                    end
                    default:
                    begin
                        line_q.push_back(qc);
                        line_q.push_back(qc);
                    end
                endcase
            end
        end
        if ($urandom_range(9) == 0)
            line_q.push_back(CH_BACKSLASH);
        else if ($urandom_range(3) == 0)
            line_q.push_back(pick_sep());
        // break a few lines: stray byte or stray quote
        if ($urandom_range(99) < 15)
        begin
            if ($urandom_range(1))
                line_q.insert($urandom_range(line_q.size()), 8'($urandom_range(255)));
            else
                line_q.insert($urandom_range(line_q.size()), CH_DQUOTE);
        end
    endfunction

    task automatic run_random(input int budget, input int max_args);
        logic [7:0] line_q[$];
        int start;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            build_line(line_q, max_args);
            send_line(line_q);
        end
    endtask

    task automatic run_phase(input logic [31:0] slots, input logic [31:0] cap, input int src,
                             input int snk, input int budget, input int max_args);
        write_reg(REG_ARG_SLOTS, slots);
        write_reg(REG_BUFFER_BYTES, cap);
        src_idle_pct = src;
        snk_stall_pct = snk;
        run_random(budget, max_args);
        settle();
    endtask

    initial
    begin
        logic [7:0] line_q[$];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, no idling
        send_item(8'd0, 1'b1);
        send_text("a\t'b\"c' \\");
        send_text("\"x");
        send_text(" \n");
        send_text("''z");
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b1);
        settle();

        run_phase(3, 24, 82, 0, 45, 3);
        run_phase(2, 12, 0, 82, 40, 3);
        run_phase(63, 8191, 38, 38, 40, 4);
        run_phase(0, 4096, 0, 0, 12, 2);
        run_phase(4, 0, 38, 38, 8, 2);
        run_phase(32, 1, 0, 0, 8, 2);

        // long receiver hold-off while a long argument streams in
        write_reg(REG_ARG_SLOTS, 32);
        write_reg(REG_BUFFER_BYTES, 4096);
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_req = 1'b1;
        line_q.delete();
        for (int i = 0; i < 36; i++)
            line_q.push_back(8'(97 + i % 26));
        send_line(line_q);
        run_random(20, 4);
        settle();

        sb.flush_leftovers();
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
